FILE: rtl/core/fwng_pkg.sv
// Shared types, constants and microcode ROM for the fixed-width number glyph emitter.
// Used by fixed_width_number_glyph_emitter_top and its assertion checker.
// No dependencies.
package fwng_pkg;

    localparam int MAX_DIGITS = 4;
    localparam int CNT_W      = $clog2(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIGITS - 1);

    localparam logic [15:0] GLYPH_PITCH = 16'd5;
    localparam logic [7:0]  BLANK_U     = 8'h58;
    localparam logic [7:0]  BLANK_V     = 8'hA4;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for x below 81920
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    // glyph kinds
    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_BLANK = 2'd1;
    localparam logic [1:0] KIND_MINUS = 2'd2;
    localparam logic [1:0] KIND_PLUS  = 2'd3;

    // commands
    localparam logic CMD_PRINT = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_DIGIT_COUNT  = 3'd0;
    localparam logic [2:0] REG_SHOW_PLUS    = 3'd1;
    localparam logic [2:0] REG_FONT_BASE_U  = 3'd2;
    localparam logic [2:0] REG_FONT_BASE_V  = 3'd3;
    localparam logic [2:0] REG_PALETTE_PAGE = 3'd4;
    localparam logic [2:0] REG_COLOR_NORMAL = 3'd5;
    localparam logic [2:0] REG_COLOR_ALT    = 3'd6;
    localparam logic [2:0] REG_USE_ALT      = 3'd7;

    localparam logic [2:0]  RST_DIGIT_COUNT  = 3'd3;
    localparam logic [7:0]  RST_FONT_BASE_U  = 8'd132;
    localparam logic [7:0]  RST_FONT_BASE_V  = 8'd164;
    localparam logic [15:0] RST_PALETTE_PAGE = 16'd14685;

    // microcode
    typedef enum logic [2:0] {
        OP_FETCH,
        OP_DIV,
        OP_SIGN,
        OP_GLYPH,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_IF
    } jcond_t;

    typedef struct packed {
        op_t        op;
        jcond_t     cond;
        logic [2:0] target;
    } ctrl_t;

    localparam logic [2:0] STEP_FETCH = 3'd0;
    localparam logic [2:0] STEP_DIV   = 3'd1;
    localparam logic [2:0] STEP_SIGN  = 3'd2;
    localparam logic [2:0] STEP_GLYPH = 3'd3;
    localparam logic [2:0] STEP_END   = 3'd4;

    function automatic ctrl_t ucode_rom(input logic [2:0] step);
        ctrl_t w;
        case (step)
            // load command returns to fetch, print falls through
            STEP_FETCH: w = '{op: OP_FETCH, cond: JC_IF,     target: STEP_FETCH};
            // repeat until every digit has been split off
            STEP_DIV:   w = '{op: OP_DIV,   cond: JC_IF,     target: STEP_DIV};
            STEP_SIGN:  w = '{op: OP_SIGN,  cond: JC_NEXT,   target: STEP_FETCH};
            // repeat while slots remain
            STEP_GLYPH: w = '{op: OP_GLYPH, cond: JC_IF,     target: STEP_GLYPH};
            STEP_END:   w = '{op: OP_NOP,   cond: JC_ALWAYS, target: STEP_FETCH};
            default:    w = '{op: OP_NOP,   cond: JC_ALWAYS, target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/fixed_width_number_glyph_emitter_top.sv
// Sequence: a print command is accepted, then 4 divide steps run, then a sign step that emits
// the sign glyph if one is needed; digit and blank glyphs follow one per cycle when m_tready is high.
// One divide unit is shared by all digits; a new command is taken only once the last glyph is registered.
// The next command is accepted while the last glyph still waits in the output register.
// Reset (synchronous, aresetn low): cursor at 0, registers at their defaults, no output valid.
module fixed_width_number_glyph_emitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value[15:0], new_cursor_x[31:16], new_cursor_y[47:32]
    input  logic        s_tuser,   // cmd
    // glyph stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // screen_x[15:0], screen_y[31:16], tex_u[39:32],
                                   // tex_v[47:40], glyph_palette[63:48], glyph_color[87:64]
    output logic [1:0]  m_tuser,   // glyph_kind
    output logic        m_tlast    // last_glyph
);
    import fwng_pkg::*;

    // configuration
    logic [2:0]  digit_count_reg;
    logic        show_plus_reg;
    logic [7:0]  font_base_u_reg;
    logic [7:0]  font_base_v_reg;
    logic [15:0] palette_page_reg;
    logic [23:0] color_normal_reg;
    logic [23:0] color_alt_reg;
    logic        use_alt_reg;

    // sequencer and datapath
    logic [2:0]       step_reg, step_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] slot_reg;
    logic [16:0]      x_reg;
    logic             neg_reg;
    logic [3:0]       bcd_reg [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] nz_reg;
    logic [15:0]      cursor_x_reg;
    logic [15:0]      cursor_y_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [7:0]  out_u_reg;
    logic [7:0]  out_v_reg;
    logic [15:0] out_pal_reg;
    logic [23:0] out_color_reg;
    logic        out_last_reg;

    ctrl_t       ctrl;
    logic        go;
    logic        test;
    logic        out_busy;
    logic        emit;
    logic [15:0] raw;
    logic [16:0] mag;
    logic [32:0] prod;
    logic [16:0] quot;
    logic [16:0] ten_quot;
    logic [16:0] rem;
    logic [2:0]  width;
    logic        sign_needed;
    logic [2:0]  slots;
    logic [3:0]  cur_digit;
    logic [23:0] color;

    assign ctrl     = ucode_rom(step_reg);
    assign out_busy = out_valid_reg && !m_tready;

    always_comb begin
        go   = 1'b1;
        test = 1'b0;
        case (ctrl.op)
            OP_FETCH: begin
                go   = s_tvalid;
                test = (s_tuser == CMD_LOAD);
            end
            OP_DIV: begin
                test = (cnt_reg != CNT_LAST);
            end
            OP_SIGN: begin
                go = !out_busy;
            end
            OP_GLYPH: begin
                go   = !out_busy;
                test = (slot_reg != '0);
            end
            default: begin
                go = 1'b1;
            end
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (go) begin
            case (ctrl.cond)
                JC_ALWAYS: step_next = ctrl.target;
                JC_IF:     step_next = test ? ctrl.target : step_reg + 3'd1;
                default:   step_next = step_reg + 3'd1;
            endcase
        end
    end

    assign s_tready = (ctrl.op == OP_FETCH);

    // magnitude of the signed value, up to 32768
    assign raw = s_tdata[15:0];
    assign mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};

    // shared divide-by-ten unit
    assign prod     = 33'(x_reg) * 33'(DIV10_MUL);
    assign quot     = 17'(prod[32:DIV10_SHIFT]);
    assign ten_quot = (quot << 3) + (quot << 1);
    assign rem      = x_reg - ten_quot;

    always_comb begin
        if (digit_count_reg < 3'd2) begin
            width = 3'd2;
        end else if (digit_count_reg > 3'(MAX_DIGITS)) begin
            width = 3'(MAX_DIGITS);
        end else begin
            width = digit_count_reg;
        end
    end

    assign sign_needed = neg_reg || (show_plus_reg && nz_reg[0]);
    assign slots       = width - 3'd1 - {2'b00, sign_needed};
    assign cur_digit   = bcd_reg[slot_reg];
    assign color       = use_alt_reg ? color_alt_reg : color_normal_reg;
    assign emit        = go && ((ctrl.op == OP_GLYPH) || (ctrl.op == OP_SIGN && sign_needed));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg  <= RST_DIGIT_COUNT;
            show_plus_reg    <= 1'b0;
            font_base_u_reg  <= RST_FONT_BASE_U;
            font_base_v_reg  <= RST_FONT_BASE_V;
            palette_page_reg <= RST_PALETTE_PAGE;
            color_normal_reg <= '0;
            color_alt_reg    <= '0;
            use_alt_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DIGIT_COUNT:  digit_count_reg  <= cfg_wdata[2:0];
                REG_SHOW_PLUS:    show_plus_reg    <= cfg_wdata[0];
                REG_FONT_BASE_U:  font_base_u_reg  <= cfg_wdata[7:0];
                REG_FONT_BASE_V:  font_base_v_reg  <= cfg_wdata[7:0];
                REG_PALETTE_PAGE: palette_page_reg <= cfg_wdata[15:0];
                REG_COLOR_NORMAL: color_normal_reg <= cfg_wdata;
                REG_COLOR_ALT:    color_alt_reg    <= cfg_wdata;
                REG_USE_ALT:      use_alt_reg      <= cfg_wdata[0];
                default:          use_alt_reg      <= use_alt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_FETCH;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else begin
            step_reg <= step_next;
            if (ctrl.op == OP_FETCH && go && s_tuser == CMD_LOAD) begin
                cursor_x_reg <= s_tdata[31:16];
                cursor_y_reg <= s_tdata[47:32];
            end else if (emit) begin
                cursor_x_reg <= cursor_x_reg + GLYPH_PITCH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            case (ctrl.op)
                OP_FETCH: begin
                    x_reg   <= mag;
                    neg_reg <= raw[15];
                    cnt_reg <= '0;
                end
                OP_DIV: begin
                    // split off one decimal digit, least significant first
                    bcd_reg[cnt_reg] <= rem[3:0];
                    nz_reg[cnt_reg]  <= (x_reg != '0);
                    x_reg            <= quot;
                    cnt_reg          <= cnt_reg + CNT_W'(1);
                end
                OP_SIGN: begin
                    slot_reg <= slots[CNT_W-1:0];
                end
                OP_GLYPH: begin
                    slot_reg <= slot_reg - CNT_W'(1);
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg     <= cursor_x_reg;
            out_y_reg     <= cursor_y_reg;
            out_color_reg <= color;
            if (ctrl.op == OP_SIGN) begin
                out_kind_reg <= neg_reg ? KIND_MINUS : KIND_PLUS;
                out_u_reg    <= '0;
                out_v_reg    <= '0;
                out_pal_reg  <= '0;
                out_last_reg <= 1'b0;
            end else begin
                out_pal_reg  <= palette_page_reg;
                out_last_reg <= (slot_reg == '0);
                // blank the leading zeros, never the final slot
                if (slot_reg != '0 && !nz_reg[slot_reg]) begin
                    out_kind_reg <= KIND_BLANK;
                    out_u_reg    <= BLANK_U;
                    out_v_reg    <= BLANK_V;
                end else begin
                    out_kind_reg <= KIND_DIGIT;
                    out_u_reg    <= font_base_u_reg + {2'b00, cur_digit, 2'b00}
                                    + {4'b0000, cur_digit};
                    out_v_reg    <= font_base_v_reg;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_color_reg, out_pal_reg, out_v_reg, out_u_reg, out_y_reg, out_x_reg};

endmodule

FILE: rtl/core/fwng_checker.sv
// Port-level assertions for the fixed-width number glyph emitter.
// Depends on fwng_pkg; bound to fixed_width_number_glyph_emitter_top below.
module fwng_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import fwng_pkg::*;

    // hold a stalled transfer
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("glyph transfer dropped while stalled");

    // the final glyph of a value is always a digit
    a_last_is_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_DIGIT)
        else $error("last glyph is not a digit");

    // sign glyphs lead the row and carry no texture or palette
    a_sign_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_MINUS || m_tuser == KIND_PLUS)
        |-> m_tdata[63:32] == '0 && !m_tlast)
        else $error("sign glyph with texture fields or last flag");

    // blank glyphs sit at the fixed texture spot
    a_blank_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_BLANK
        |-> m_tdata[39:32] == BLANK_U && m_tdata[47:40] == BLANK_V)
        else $error("blank glyph at wrong texture spot");

    // no new command is taken while a glyph row is being built
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && m_tready |-> !s_tready)
        else $error("command accepted in the middle of a glyph row");

endmodule

bind fixed_width_number_glyph_emitter_top fwng_checker u_fwng_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
